// ----- rtl/amqp_frame_deframer_macros.svh -----
// assertion macros for the frame deframer
`ifndef AMQP_FRAME_DEFRAMER_MACROS_SVH
`define AMQP_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled in reset
`define AFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define AFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/afd_pkg.sv -----
package afd_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_END     = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_PAYLOAD  = 3'd0;
  localparam logic [2:0] ST_GOOD     = 3'd1;
  localparam logic [2:0] ST_BAD_END  = 3'd2;
  localparam logic [2:0] ST_OVERSIZE = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;

  // protocol constants
  localparam logic [7:0]  FRAME_END_BYTE    = 8'hCE;
  localparam logic [7:0]  METHOD_TYPE       = 8'd1;
  localparam logic [2:0]  HDR_LAST          = 3'd6;
  localparam logic [31:0] METHOD_HEAD_BYTES = 32'd4;
  localparam logic [31:0] CLASS_BYTES       = 32'd2;
  localparam logic [31:0] MAX_LEN_RESET     = 32'd131072;

endpackage

// ----- rtl/amqp_frame_deframer.sv -----
// AMQP 0-9-1 frame deframer. Takes the raw frame stream one byte per input
// transaction and sustains one byte per clock while no result is stalled:
// every byte is handled by a single pass of counter compare and field capture
// between the parser state and one result register; results come next cycle.
// The 7 header bytes (type, big-endian channel, big-endian size) give no
// result; each payload byte comes out with status 0 and its offset; the end
// byte gives one end result (status 1 good, 2 bad terminator, 4 method frame
// shorter than 4 bytes) with frame_done set, carrying the class and method
// identifiers for method frames of at least 4 bytes. A size above the size
// limit gives status 3 straight after the header, then the payload and end
// byte are dropped without results. No resynchronisation: the byte after
// each frame is taken as the next header. in_stall is raised only while a
// result is held by out_stall. cfg_ready is always high; write the size limit
// only while the block is idle.
`include "amqp_frame_deframer_macros.svh"

module amqp_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  frame_type,
  output logic [15:0] channel,
  output logic [31:0] payload_size,
  output logic [31:0] payload_offset,
  output logic [7:0]  payload_byte,
  output logic [15:0] class_ident,
  output logic [15:0] method_ident,
  output logic        frame_done
);
  import afd_pkg::*;

  // parser state
  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [15:0] cur_channel, cur_channel_next;
  logic [31:0] declared_size, declared_size_next;
  logic [31:0] byte_counter, byte_counter_next;
  logic [15:0] class_word, class_word_next;
  logic [15:0] method_word, method_word_next;
  logic [31:0] max_len;

  // result of the byte being taken
  logic        res_valid;
  logic [2:0]  res_status;
  logic [31:0] res_offset;
  logic [7:0]  res_byte;
  logic [15:0] res_class;
  logic [15:0] res_method;
  logic        res_done;

  logic        in_fire;
  logic        out_load;
  logic [31:0] count_inc;
  logic        is_method;
  logic        long_enough;

  // handshake: take a byte unless the held result is stalled
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = !out_valid || !out_stall;

  assign count_inc   = byte_counter + 32'd1;
  assign is_method   = (cur_type == METHOD_TYPE);
  assign long_enough = (declared_size >= METHOD_HEAD_BYTES);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  // next state and result
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    cur_type_next      = cur_type;
    cur_channel_next   = cur_channel;
    declared_size_next = declared_size;
    byte_counter_next  = byte_counter;
    class_word_next    = class_word;
    method_word_next   = method_word;
    res_valid          = 1'b0;
    res_status         = ST_PAYLOAD;
    res_offset         = '0;
    res_byte           = '0;
    res_class          = '0;
    res_method         = '0;
    res_done           = 1'b0;
    if (in_fire) begin
      case (phase)
        PH_HEADER: begin
          // gather type, channel and size
          case (header_count)
            3'd0: begin
              cur_type_next      = data_byte;
              cur_channel_next   = '0;
              declared_size_next = '0;
            end
            3'd1, 3'd2: begin
              cur_channel_next = {cur_channel[7:0], data_byte};
            end
            default: begin
              declared_size_next = {declared_size[23:0], data_byte};
            end
          endcase
          if (header_count == HDR_LAST) begin
            header_count_next = '0;
            byte_counter_next = '0;
            class_word_next   = '0;
            method_word_next  = '0;
            if (declared_size_next > max_len) begin
              phase_next = PH_SKIP;
              res_valid  = 1'b1;
              res_status = ST_OVERSIZE;
              res_done   = 1'b1;
            end else if (declared_size_next == '0) begin
              phase_next = PH_END;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            header_count_next = header_count + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          // capture class and method words of method frames
          if (is_method) begin
            if (byte_counter < CLASS_BYTES) begin
              class_word_next = {class_word[7:0], data_byte};
            end else if (byte_counter < METHOD_HEAD_BYTES) begin
              method_word_next = {method_word[7:0], data_byte};
            end
          end
          res_valid         = 1'b1;
          res_status        = ST_PAYLOAD;
          res_offset        = byte_counter;
          res_byte          = data_byte;
          byte_counter_next = count_inc;
          if (count_inc >= declared_size) begin
            phase_next = PH_END;
          end
        end
        PH_END: begin
          // terminator check and frame report
          res_valid = 1'b1;
          res_done  = 1'b1;
          if (data_byte != FRAME_END_BYTE) begin
            res_status = ST_BAD_END;
          end else if (is_method && !long_enough) begin
            res_status = ST_SHORT;
          end else begin
            res_status = ST_GOOD;
          end
          if (is_method && long_enough) begin
            res_class  = class_word;
            res_method = method_word;
          end
          phase_next        = PH_HEADER;
          header_count_next = '0;
          byte_counter_next = '0;
          class_word_next   = '0;
          method_word_next  = '0;
        end
        PH_SKIP: begin
          // drop payload and end byte of an oversize frame
          if (byte_counter >= declared_size) begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
            byte_counter_next = '0;
            class_word_next   = '0;
            method_word_next  = '0;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= '0;
      cur_type      <= '0;
      cur_channel   <= '0;
      declared_size <= '0;
      byte_counter  <= '0;
      class_word    <= '0;
      method_word   <= '0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      cur_type      <= cur_type_next;
      cur_channel   <= cur_channel_next;
      declared_size <= declared_size_next;
      byte_counter  <= byte_counter_next;
      class_word    <= class_word_next;
      method_word   <= method_word_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_fire && res_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (out_load && in_fire && res_valid) begin
      status         <= res_status;
      frame_type     <= cur_type_next;
      channel        <= cur_channel_next;
      payload_size   <= declared_size_next;
      payload_offset <= res_offset;
      payload_byte   <= res_byte;
      class_ident    <= res_class;
      method_ident   <= res_method;
      frame_done     <= res_done;
    end
  end

  // checks on parser consistency
  `AFD_ASSERT_NOW(a_done_matches_status, clk, rst, out_valid, (frame_done == (status != ST_PAYLOAD)), "frame_done disagrees with status")
  `AFD_ASSERT_NOW(a_payload_in_range, clk, rst, (phase == PH_PAYLOAD), (byte_counter < declared_size), "payload offset past declared size")
  `AFD_ASSERT_NOW(a_skip_in_range, clk, rst, (phase == PH_SKIP), (byte_counter <= declared_size), "skip counter past declared size")
  `AFD_ASSERT_NOW(a_header_count_idle, clk, rst, (phase != PH_HEADER), (header_count == 3'd0), "header count not cleared after header")
  `AFD_ASSERT_NEXT(a_header_no_result, clk, rst, (in_fire && (phase == PH_HEADER) && (header_count != HDR_LAST)), (out_valid == $past(out_valid && out_stall)), "result produced for a header byte")

endmodule
